FILE: hdl/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HSVC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsv_to_rgb_converter assertion failed");

// Condition in one cycle forces a consequence in the next.
`define HSVC_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

`endif

FILE: hdl/hsvc_pkg.sv
// Shared types and constants of the HSV to RGB converter.
package hsvc_pkg;

    localparam int PIPE_DEPTH = 7;

    localparam logic [8:0]  HUE_TURN   = 9'd360;
    localparam logic [5:0]  SECTOR_W   = 6'd60;
    localparam logic [6:0]  PCT_FULL   = 7'd100;

    // Reciprocal multipliers for exact floor division on bounded operands.
    localparam logic [7:0]  HUE_RECIP  = 8'd182;        // /360 estimate, >> 16, may be one low
    localparam logic [10:0] SEC_RECIP  = 11'd1093;      // /60 for values below 360, >> 16
    localparam logic [20:0] TOP_RECIP  = 21'd1336965;   // *255/100, >> 19
    localparam logic [12:0] BOT_RECIP  = 13'd5243;      // /100 for values up to 25500, >> 19
    localparam logic [14:0] RAMP_RECIP = 15'd17477;     // /60 for values up to 15045, >> 20

    typedef enum logic [2:0] {
        SEC_RED_GRN = 3'd0,
        SEC_GRN_RED = 3'd1,
        SEC_GRN_BLU = 3'd2,
        SEC_BLU_GRN = 3'd3,
        SEC_BLU_RED = 3'd4,
        SEC_RED_BLU = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector    sector;
        logic [5:0] offset;
    } t_hue_pos;

endpackage

FILE: hdl/hsvc_hue_unit.sv
// Four-stage hue reduction: modulo 360, then sector and offset within the sector.
module hsvc_hue_unit (
    input  logic              i_clk,
    input  logic [15:0]       i_hue,
    output hsvc_pkg::t_hue_pos o_pos
);
    import hsvc_pkg::*;

    logic [23:0] r_prod;
    logic [15:0] r_hue1;
    logic [15:0] quot_x;
    logic [15:0] rem0;
    logic [8:0]  n_red;
    logic [8:0]  r_red;
    logic [19:0] r_sprod;
    logic [8:0]  r_hue3;
    logic [2:0]  sec_bits;
    logic [8:0]  sec_x;
    logic [8:0]  off_wide;
    t_hue_pos    n_pos;
    t_hue_pos    r_pos;

    always_comb begin
        quot_x = 16'(r_prod[23:16]) * 16'(HUE_TURN);
        rem0   = r_hue1 - quot_x;
        if (rem0 >= 16'(HUE_TURN)) begin
            n_red = 9'(rem0 - 16'(HUE_TURN));
        end else begin
            n_red = 9'(rem0);
        end
    end

    always_comb begin
        sec_bits     = r_sprod[18:16];
        sec_x        = 9'(sec_bits) * 9'(SECTOR_W);
        off_wide     = r_hue3 - sec_x;
        n_pos.sector = t_sector'(sec_bits);
        n_pos.offset = off_wide[5:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= 24'(i_hue) * 24'(HUE_RECIP);
        r_hue1  <= i_hue;
        r_red   <= n_red;
        r_sprod <= 20'(r_red) * 20'(SEC_RECIP);
        r_hue3  <= r_red;
        r_pos   <= n_pos;
    end

    assign o_pos = r_pos;

endmodule

FILE: hdl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
//
//  channel | handshake              | fields
//  --------+------------------------+-------------------------------------------
//  input   | start, busy            | i_hue[15:0], i_saturation[6:0], i_brightness[6:0]
//  result  | o_valid (one cycle)    | o_red[7:0], o_green[7:0], o_blue[7:0]
//
//  A beat may enter every cycle while busy is low; results pass r1 to r6, then r_red.
//  Depth is set by the chain of reciprocal multiplies: level, bottom level, ramp.
//  Synchronous reset clears the valid pipeline; busy is high during reset and
//  for the cycle after it, and low otherwise.
//  The receiver takes every result; nothing stalls.
module hsv_to_rgb_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [15:0] i_hue,
    input  logic [6:0] i_saturation,
    input  logic [6:0] i_brightness,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    import hsvc_pkg::*;

    `include "hsv_to_rgb_converter_assert.svh"

    logic                  r_busy;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  accept;

    logic [6:0]  sat_cl;
    logic [6:0]  val_cl;
    logic [27:0] top_prod;
    logic [27:0] bot_prod;
    logic [28:0] ramp_prod;

    logic [7:0]  r1_top;
    logic [6:0]  r1_sat;
    logic [7:0]  r2_top;
    logic [14:0] r2_bnum;
    logic [7:0]  r3_top;
    logic [7:0]  r3_bot;
    logic [7:0]  r4_top;
    logic [7:0]  r4_bot;
    logic [7:0]  r4_diff;
    t_hue_pos    hue_pos;
    logic [7:0]  r5_top;
    logic [7:0]  r5_bot;
    t_sector     r5_sector;
    logic [13:0] r5_rnum;
    logic [7:0]  r6_top;
    logic [7:0]  r6_bot;
    t_sector     r6_sector;
    logic [7:0]  r6_ramp;

    logic [7:0]  rise;
    logic [7:0]  fall;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], accept};
        end
    end

    hsvc_hue_unit u_hue (
        .i_clk (i_clk),
        .i_hue (i_hue),
        .o_pos (hue_pos)
    );

    always_comb begin
        sat_cl    = (i_saturation > PCT_FULL) ? PCT_FULL : i_saturation;
        val_cl    = (i_brightness > PCT_FULL) ? PCT_FULL : i_brightness;
        top_prod  = 28'(val_cl) * 28'(TOP_RECIP);
        bot_prod  = 28'(r2_bnum) * 28'(BOT_RECIP);
        ramp_prod = 29'(r5_rnum) * 29'(RAMP_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r1_top    <= top_prod[26:19];
        r1_sat    <= sat_cl;
        r2_top    <= r1_top;
        r2_bnum   <= 15'(r1_top) * 15'(PCT_FULL - r1_sat);
        r3_top    <= r2_top;
        r3_bot    <= bot_prod[26:19];
        r4_top    <= r3_top;
        r4_bot    <= r3_bot;
        r4_diff   <= r3_top - r3_bot;
        r5_top    <= r4_top;
        r5_bot    <= r4_bot;
        r5_sector <= hue_pos.sector;
        r5_rnum   <= 14'(r4_diff) * 14'(hue_pos.offset);
        r6_top    <= r5_top;
        r6_bot    <= r5_bot;
        r6_sector <= r5_sector;
        r6_ramp   <= ramp_prod[27:20];
        r_red     <= n_red;
        r_green   <= n_green;
        r_blue    <= n_blue;
    end

    always_comb begin
        rise = r6_bot + r6_ramp;
        fall = r6_top - r6_ramp;
        unique case (r6_sector)
            SEC_RED_GRN: begin
                n_red = r6_top;  n_green = rise;    n_blue = r6_bot;
            end
            SEC_GRN_RED: begin
                n_red = fall;    n_green = r6_top;  n_blue = r6_bot;
            end
            SEC_GRN_BLU: begin
                n_red = r6_bot;  n_green = r6_top;  n_blue = rise;
            end
            SEC_BLU_GRN: begin
                n_red = r6_bot;  n_green = fall;    n_blue = r6_top;
            end
            SEC_BLU_RED: begin
                n_red = rise;    n_green = r6_bot;  n_blue = r6_top;
            end
            default: begin
                n_red = r6_top;  n_green = r6_bot;  n_blue = fall;
            end
        endcase
    end

    assign busy    = r_busy;
    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    `HSVC_ASSERT(a_accept_gives_result, accept |-> ##PIPE_DEPTH o_valid)
    `HSVC_ASSERT(a_result_has_beat, o_valid |-> $past(accept, PIPE_DEPTH))
    `HSVC_ASSERT_NEXT(a_ramp_in_range, r_vld[PIPE_DEPTH-2], r_red >= $past(r6_bot) || r_green >= $past(r6_bot))
    `HSVC_ASSERT(a_ramp_bounded, r_vld[PIPE_DEPTH-2] |-> (r6_ramp <= r6_top - r6_bot))

endmodule
